// ----- hdl/sgsa_pkg.sv -----
`default_nettype none
package sgsa_pkg;

  localparam int unsigned ImagePixelsDefault = 65536;
  localparam int unsigned MapEntriesDefault  = 4096;

  localparam int unsigned KindW   = 2;
  localparam int unsigned CoordW  = 16;
  localparam int unsigned ValW    = 32;
  localparam int unsigned IdxW    = 24;
  localparam int unsigned AccW    = 48;
  localparam int unsigned StatW   = 2;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDataW = 13;
  localparam int unsigned ImgDimW = 9;
  localparam int unsigned MapDimW = 13;

  typedef enum logic [KindW-1:0] {
    KIND_LOAD  = 2'd0,
    KIND_CLEAR = 2'd1,
    KIND_ACCUM = 2'd2,
    KIND_READ  = 2'd3
  } kind_t;

  typedef enum logic [StatW-1:0] {
    STAT_OK    = 2'd0,
    STAT_COL   = 2'd1,
    STAT_ROW   = 2'd2,
    STAT_PARAM = 2'd3
  } status_t;

  typedef enum logic [CfgIdxW-1:0] {
    REG_IMAGE_WIDTH  = 2'd0,
    REG_IMAGE_HEIGHT = 2'd1,
    REG_MAP_WIDTH    = 2'd2,
    REG_MAP_HEIGHT   = 2'd3
  } reg_idx_t;

  // handshake between sequencer and the shared divider
  typedef struct packed {
    logic start;
  } div_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage
`default_nettype wire

// ----- hdl/sgsa_divider.sv -----
`default_nettype none
// restoring divider, one quotient bit per cycle
module sgsa_divider (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire sgsa_pkg::div_req_t       req,
  input  wire logic [sgsa_pkg::IdxW-1:0]    dividend,
  input  wire logic [sgsa_pkg::MapDimW-1:0] divisor,
  output sgsa_pkg::div_stat_t           stat,
  output logic [sgsa_pkg::IdxW-1:0]     quotient
);
  import sgsa_pkg::*;

  localparam int unsigned CntW = $clog2(IdxW + 1);

  logic [IdxW-1:0]    quo;
  logic [MapDimW:0]   rem;
  logic [MapDimW-1:0] dsr;
  logic [CntW-1:0]    cnt;
  logic               busy;
  logic               done;
  logic [MapDimW:0]   trial;
  logic [MapDimW+1:0] diff;

  always_comb begin
    trial = {rem[MapDimW-1:0], quo[IdxW-1]};
    diff  = {1'b0, trial} - {2'b00, dsr};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= CntW'(IdxW);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CntW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      quo <= dividend;
      rem <= '0;
      dsr <= divisor;
    end else if (busy) begin
      if (!diff[MapDimW+1]) begin
        rem <= diff[MapDimW:0];
        quo <= {quo[IdxW-2:0], 1'b1};
      end else begin
        rem <= trial;
        quo <= {quo[IdxW-2:0], 1'b0};
      end
    end
  end

  assign stat.busy = busy;
  assign stat.done = done;
  assign quotient  = quo;

`ifndef NO_ASSERTIONS
  a_start_idle: assert property (@(posedge clk) disable iff (rst) req.start |-> !busy)
    else $error("divider started while busy");
  a_done_end: assert property (@(posedge clk) disable iff (rst) done |-> $past(busy))
    else $error("divider done without run");
  a_done_clear: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("divider done while busy");
`endif
endmodule
`default_nettype wire

// ----- hdl/sgsa_mac.sv -----
`default_nettype none
// shared multiply, round and saturating add, one channel per use
module sgsa_mac (
  input  wire logic                            clk,
  input  wire logic signed [sgsa_pkg::ValW-1:0] grad,
  input  wire logic signed [sgsa_pkg::ValW-1:0] deriv,
  input  wire logic signed [sgsa_pkg::AccW-1:0] acc,
  output logic signed [sgsa_pkg::AccW-1:0]      sum
);
  import sgsa_pkg::*;

  localparam logic signed [AccW+1:0] AccMax = (AccW+2)'({1'b0, {(AccW-1){1'b1}}});
  localparam logic signed [AccW+1:0] AccMin = -AccMax - 1;

  logic signed [2*ValW-1:0] prod;
  logic signed [2*ValW:0]   rnd;
  logic signed [AccW+1:0]   scaled;
  logic signed [AccW+1:0]   total;

  // registered product stage
  always_ff @(posedge clk) begin
    prod <= grad * deriv;
  end

  always_comb begin
    rnd    = {prod[2*ValW-1], prod} + (2*ValW+1)'(33'sh8000);
    scaled = (AccW+2)'(rnd >>> 16);
    total  = scaled + {{2{acc[AccW-1]}}, acc};
    if (total > AccMax) sum = AccMax[AccW-1:0];
    else if (total < AccMin) sum = AccMin[AccW-1:0];
    else sum = total[AccW-1:0];
  end
endmodule
`default_nettype wire

// ----- hdl/sparse_gradient_scatter_accumulate.sv -----
`default_nettype none
// channel | signals                                      | direction
// in      | in_valid/in_ready, kind .. deriv_third       | to block
// out     | out_valid/out_ready, status, sum_*_out       | from block
// cfg     | cfg_we, cfg_index, cfg_data                  | to block
// an accumulate runs the bit-serial index divider, then three read, multiply, add
// rounds through the shared mac, one per channel; a read runs the divider and then
// fetches all three planes, and a failed accumulate or read stops after the check
// reset is synchronous; memories are not cleared, issue a clear item before use.
// the block takes no item while one is in work or its result waits, so holding
// off the result also holds off the next item
module sparse_gradient_scatter_accumulate #(
  parameter int unsigned IMAGE_PIXELS = sgsa_pkg::ImagePixelsDefault,
  parameter int unsigned MAP_ENTRIES  = sgsa_pkg::MapEntriesDefault
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               in_valid,
  output logic                                    in_ready,
  input  wire logic [sgsa_pkg::KindW-1:0]         kind,
  input  wire logic [sgsa_pkg::CoordW-1:0]        pixel_column,
  input  wire logic [sgsa_pkg::CoordW-1:0]        pixel_row,
  input  wire logic signed [sgsa_pkg::ValW-1:0]   pixel_gradient,
  input  wire logic [sgsa_pkg::IdxW-1:0]          param_index,
  input  wire logic signed [sgsa_pkg::ValW-1:0]   deriv_first,
  input  wire logic signed [sgsa_pkg::ValW-1:0]   deriv_second,
  input  wire logic signed [sgsa_pkg::ValW-1:0]   deriv_third,
  output logic                                    out_valid,
  input  wire logic                               out_ready,
  output logic [sgsa_pkg::StatW-1:0]              status,
  output logic signed [sgsa_pkg::AccW-1:0]        sum_first_out,
  output logic signed [sgsa_pkg::AccW-1:0]        sum_second_out,
  output logic signed [sgsa_pkg::AccW-1:0]        sum_third_out,
  input  wire logic                               cfg_we,
  input  wire logic [sgsa_pkg::CfgIdxW-1:0]       cfg_index,
  input  wire logic [sgsa_pkg::CfgDataW-1:0]      cfg_data
);
  import sgsa_pkg::*;

  localparam int unsigned PixAW = $clog2(IMAGE_PIXELS);
  localparam int unsigned MapAW = $clog2(MAP_ENTRIES);

  typedef enum logic [10:0] {
    S_IDLE  = 11'b00000000001,
    S_ADDR  = 11'b00000000010,
    S_DIV   = 11'b00000000100,
    S_CHECK = 11'b00000001000,
    S_RD    = 11'b00000010000,
    S_MUL   = 11'b00000100000,
    S_ADD   = 11'b00001000000,
    S_CLEAR = 11'b00010000000,
    S_LOAD  = 11'b00100000000,
    S_FETCH = 11'b01000000000,
    S_OUT   = 11'b10000000000
  } state_t;

  state_t state, state_next;

  logic [ImgDimW-1:0] image_width, image_height;
  logic [MapDimW-1:0] map_width, map_height;

  kind_t              k;
  logic [CoordW-1:0]  col, row;
  logic signed [ValW-1:0] grad_in, d1, d2, d3;
  logic [IdxW-1:0]    idx;
  logic [PixAW-1:0]   paddr;
  logic [1:0]         ch;
  logic [MapAW-1:0]   clr_addr;
  logic               clr_last;

  logic signed [ValW-1:0] image_mem [IMAGE_PIXELS];
  logic signed [AccW-1:0] acc_mem [3][MAP_ENTRIES];
  logic signed [ValW-1:0] g_rd;
  logic signed [AccW-1:0] acc_rd;
  logic signed [AccW-1:0] r1, r2, r3;
  logic [StatW-1:0]   stat_r;

  div_req_t           dreq;
  div_stat_t          dstat;
  logic [IdxW-1:0]    quo;

  logic signed [ValW-1:0] dsel;
  logic signed [AccW-1:0] mac_sum;
  logic [2*CoordW-1:0]    lin;
  logic [IdxW-1:0]        map_lim;

  assign in_ready = (state == S_IDLE);
  assign out_valid = (state == S_OUT);
  assign map_lim = IdxW'(MAP_ENTRIES);

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= ImgDimW'(256);
      image_height <= ImgDimW'(256);
      map_width    <= MapDimW'(64);
      map_height   <= MapDimW'(64);
    end else if (cfg_we) begin
      unique case (reg_idx_t'(cfg_index))
        REG_IMAGE_WIDTH:  image_width  <= cfg_data[ImgDimW-1:0];
        REG_IMAGE_HEIGHT: image_height <= cfg_data[ImgDimW-1:0];
        REG_MAP_WIDTH:    map_width    <= cfg_data;
        REG_MAP_HEIGHT:   map_height   <= cfg_data;
        default: ;
      endcase
    end
  end

  // every accumulate or read divides; an image bound failure keeps its own code
  assign dreq.start = (state == S_ADDR) && (k != KIND_LOAD);

  sgsa_divider u_div (
    .clk      (clk),
    .rst      (rst),
    .req      (dreq),
    .dividend (idx),
    .divisor  (map_width),
    .stat     (dstat),
    .quotient (quo)
  );

  always_comb begin
    unique case (ch)
      2'd0:    dsel = d1;
      2'd1:    dsel = d2;
      default: dsel = d3;
    endcase
  end

  sgsa_mac u_mac (
    .clk   (clk),
    .grad  (g_rd),
    .deriv (dsel),
    .acc   (acc_rd),
    .sum   (mac_sum)
  );

  assign lin = row * image_width + col;
  assign clr_last = (clr_addr == MapAW'(MAP_ENTRIES - 1));

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:  if (in_valid) begin
        unique case (kind_t'(kind))
          KIND_CLEAR: state_next = S_CLEAR;
          default:    state_next = S_ADDR;
        endcase
      end
      S_ADDR: begin
        if (k == KIND_LOAD) state_next = S_LOAD;
        else if (dreq.start) state_next = S_DIV;
        else state_next = S_OUT;
      end
      S_DIV:   if (dstat.done) state_next = S_CHECK;
      S_CHECK: state_next = (stat_r == STAT_OK && map_width != '0 &&
                             quo < IdxW'(map_height) && idx < map_lim) ? S_RD : S_OUT;
      S_RD:    state_next = (k == KIND_READ) ? S_FETCH : S_MUL;
      S_MUL:   state_next = S_ADD;
      S_ADD:   state_next = (ch == 2'd2) ? S_OUT : S_RD;
      S_FETCH: state_next = S_OUT;
      S_CLEAR: if (clr_last) state_next = S_OUT;
      S_LOAD:  state_next = S_OUT;
      S_OUT:   if (out_ready) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ch <= '0;
      clr_addr <= '0;
      stat_r <= STAT_OK;
    end else begin
      unique case (state)
        S_IDLE: begin
          ch <= '0;
          clr_addr <= '0;
          stat_r <= STAT_OK;
        end
        S_ADDR: begin
          if (k != KIND_READ) begin
            if (col >= CoordW'(image_width)) stat_r <= STAT_COL;
            else if (row >= CoordW'(image_height)) stat_r <= STAT_ROW;
          end
        end
        S_CHECK: begin
          if (stat_r == STAT_OK &&
              !(map_width != '0 && quo < IdxW'(map_height) && idx < map_lim))
            stat_r <= STAT_PARAM;
        end
        S_ADD:   ch <= ch + 2'd1;
        S_CLEAR: clr_addr <= clr_addr + 1'b1;
        default: ;
      endcase
    end
  end

  // item capture and pixel address
  always_ff @(posedge clk) begin
    if (state == S_IDLE && in_valid) begin
      k       <= kind_t'(kind);
      col     <= pixel_column;
      row     <= pixel_row;
      grad_in <= pixel_gradient;
      idx     <= param_index;
      d1      <= deriv_first;
      d2      <= deriv_second;
      d3      <= deriv_third;
    end
    if (state == S_ADDR) paddr <= lin[PixAW-1:0];
  end

  // gradient image: written by load, read while the divider runs
  always_ff @(posedge clk) begin
    if (state == S_LOAD && stat_r == STAT_OK) image_mem[paddr] <= grad_in;
    g_rd <= image_mem[paddr];
  end

  // accumulator planes
  always_ff @(posedge clk) begin
    if (state == S_CLEAR) begin
      acc_mem[0][clr_addr] <= '0;
      acc_mem[1][clr_addr] <= '0;
      acc_mem[2][clr_addr] <= '0;
    end else if (state == S_ADD) begin
      acc_mem[ch][idx[MapAW-1:0]] <= mac_sum;
    end
    acc_rd <= acc_mem[ch][idx[MapAW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE) begin
      r1 <= '0;
      r2 <= '0;
      r3 <= '0;
    end else if (state == S_FETCH) begin
      r1 <= acc_mem[0][idx[MapAW-1:0]];
      r2 <= acc_mem[1][idx[MapAW-1:0]];
      r3 <= acc_mem[2][idx[MapAW-1:0]];
    end
  end

  assign status         = stat_r;
  assign sum_first_out  = r1;
  assign sum_second_out = r2;
  assign sum_third_out  = r3;

`ifndef NO_ASSERTIONS
  a_onehot: assert property (@(posedge clk) disable iff (rst) $onehot(state))
    else $error("state not one-hot");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(status))
    else $error("result dropped");
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !in_ready)
    else $error("accept while result waits");
  a_div_only_in_div: assert property (@(posedge clk) disable iff (rst)
    dstat.done |-> state == S_DIV)
    else $error("divider done outside division");
`endif
endmodule
`default_nettype wire

// ----- tb/sv/tb_sparse_gradient_scatter_accumulate.sv -----
`timescale 1ns / 1ps
module tb_sparse_gradient_scatter_accumulate;
  import sgsa_pkg::*;

  localparam int unsigned PixelCount = 65536;
  localparam int unsigned EntryCount = 4096;
  localparam longint AccMax = 64'sh0000_7FFF_FFFF_FFFF;
  localparam longint AccMin = -AccMax - 1;
  localparam logic signed [ValW-1:0] ValMax = 32'sh7FFF_FFFF;
  localparam logic signed [ValW-1:0] ValMin = 32'sh8000_0000;

  typedef struct {
    kind_t                   kind;
    logic [CoordW-1:0]       col;
    logic [CoordW-1:0]       row;
    logic signed [ValW-1:0]  grad;
    logic [IdxW-1:0]         idx;
    logic signed [ValW-1:0]  d1;
    logic signed [ValW-1:0]  d2;
    logic signed [ValW-1:0]  d3;
  } scatter_item_t;

  typedef struct {
    status_t                 status;
    logic signed [AccW-1:0]  s1;
    logic signed [AccW-1:0]  s2;
    logic signed [AccW-1:0]  s3;
  } entry_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [KindW-1:0] kind = '0;
  logic [CoordW-1:0] pixel_column = '0;
  logic [CoordW-1:0] pixel_row = '0;
  logic signed [ValW-1:0] pixel_gradient = '0;
  logic [IdxW-1:0] param_index = '0;
  logic signed [ValW-1:0] deriv_first = '0;
  logic signed [ValW-1:0] deriv_second = '0;
  logic signed [ValW-1:0] deriv_third = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [StatW-1:0] status;
  logic signed [AccW-1:0] sum_first_out;
  logic signed [AccW-1:0] sum_second_out;
  logic signed [AccW-1:0] sum_third_out;
  logic cfg_we = 1'b0;
  logic [CfgIdxW-1:0] cfg_index = '0;
  logic [CfgDataW-1:0] cfg_data = '0;

  sparse_gradient_scatter_accumulate DUT (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .kind(kind), .pixel_column(pixel_column), .pixel_row(pixel_row),
    .pixel_gradient(pixel_gradient), .param_index(param_index),
    .deriv_first(deriv_first), .deriv_second(deriv_second), .deriv_third(deriv_third),
    .out_valid(out_valid), .out_ready(out_ready), .status(status),
    .sum_first_out(sum_first_out), .sum_second_out(sum_second_out),
    .sum_third_out(sum_third_out),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // register shadow, only changed while the block is idle
  int unsigned img_w = 256;
  int unsigned img_h = 256;
  int unsigned map_w = 64;
  int unsigned map_h = 64;

  logic signed [ValW-1:0] grad_image [PixelCount];
  longint acc_first [EntryCount];
  longint acc_second [EntryCount];
  longint acc_third [EntryCount];
  bit pixel_loaded [PixelCount];

  scatter_item_t pending_items[$];
  entry_result_t expected_entries[$];
  int unsigned mismatches = 0;
  int unsigned results_seen = 0;
  int unsigned cycle_count = 0;

  always @(posedge clk) cycle_count <= cycle_count + 1;

  function automatic bit quiet_window();
    return cycle_count >= 15000 && cycle_count < 35000;
  endfunction

  function automatic int unsigned pixel_addr(int unsigned c, int unsigned r);
    return (r * img_w + c) % PixelCount;
  endfunction

  function automatic status_t image_status(int unsigned c, int unsigned r);
    if (c >= img_w) return STAT_COL;
    if (r >= img_h) return STAT_ROW;
    return STAT_OK;
  endfunction

  function automatic bit entry_valid(int unsigned i);
    if (map_w == 0) return 1'b0;
    if (i / map_w >= map_h) return 1'b0;
    return i < EntryCount;
  endfunction

  function automatic longint scaled_product(logic signed [ValW-1:0] g,
                                            logic signed [ValW-1:0] d);
    longint p;
    p = longint'(g) * longint'(d);
    return (p + 64'sd32768) >>> 16;
  endfunction

  function automatic longint sat_add(longint a, longint b);
    longint s;
    s = a + b;
    if (s > AccMax) return AccMax;
    if (s < AccMin) return AccMin;
    return s;
  endfunction

  // predicts the result of one accepted item and updates the shadow state
  task automatic scatter_predict(input scatter_item_t it);
    entry_result_t r;
    logic signed [ValW-1:0] g;
    r = '{STAT_OK, '0, '0, '0};
    case (it.kind)
      KIND_LOAD: begin
        r.status = image_status(it.col, it.row);
        if (r.status == STAT_OK) grad_image[pixel_addr(it.col, it.row)] = it.grad;
      end
      KIND_CLEAR: begin
        for (int i = 0; i < EntryCount; i++) begin
          acc_first[i] = 0;
          acc_second[i] = 0;
          acc_third[i] = 0;
        end
      end
      KIND_ACCUM: begin
        r.status = image_status(it.col, it.row);
        if (r.status == STAT_OK && !entry_valid(it.idx)) r.status = STAT_PARAM;
        if (r.status == STAT_OK) begin
          g = grad_image[pixel_addr(it.col, it.row)];
          acc_first[it.idx] = sat_add(acc_first[it.idx], scaled_product(g, it.d1));
          acc_second[it.idx] = sat_add(acc_second[it.idx], scaled_product(g, it.d2));
          acc_third[it.idx] = sat_add(acc_third[it.idx], scaled_product(g, it.d3));
        end
      end
      default: begin
        if (!entry_valid(it.idx)) begin
          r.status = STAT_PARAM;
        end else begin
          r.s1 = acc_first[it.idx][AccW-1:0];
          r.s2 = acc_second[it.idx][AccW-1:0];
          r.s3 = acc_third[it.idx][AccW-1:0];
        end
      end
    endcase
    expected_entries = {expected_entries, r};
  endtask

  // driver
  scatter_item_t cur_item;
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) scatter_predict(cur_item);
      if (!in_valid || in_ready) begin
        if (pending_items.size() > 0 && (quiet_window() || $urandom_range(99) >= 15)) begin
          cur_item = pending_items.pop_front();
          kind <= cur_item.kind;
          pixel_column <= cur_item.col;
          pixel_row <= cur_item.row;
          pixel_gradient <= cur_item.grad;
          param_index <= cur_item.idx;
          deriv_first <= cur_item.d1;
          deriv_second <= cur_item.d2;
          deriv_third <= cur_item.d3;
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("%0t: %s got %0h expected %0h", $realtime, what, got, want);
    mismatches++;
  endtask

  // monitor, with one long hold-off so the block backs up
  int unsigned hold_left = 0;
  bit held_once = 1'b0;
  always @(posedge clk) begin
    entry_result_t w;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        results_seen++;
        if (expected_entries.size() == 0) begin
          report_mismatch("result with nothing expected, status", status, 0);
        end else begin
          w = expected_entries.pop_front();
          if (status !== w.status) report_mismatch("status", status, w.status);
          if (sum_first_out !== w.s1) report_mismatch("sum_first_out", sum_first_out, w.s1);
          if (sum_second_out !== w.s2) report_mismatch("sum_second_out", sum_second_out, w.s2);
          if (sum_third_out !== w.s3) report_mismatch("sum_third_out", sum_third_out, w.s3);
        end
      end
      if (!held_once && results_seen == 300) begin
        held_once = 1'b1;
        hold_left = 500;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= quiet_window() || $urandom_range(99) >= 15;
      end
    end
  end

  function automatic logic signed [ValW-1:0] rand_val();
    case ($urandom_range(9))
      0: return ValMax;
      1: return ValMin;
      2: return '0;
      3: return $urandom_range(65535) - 32768;
      default: return $urandom;
    endcase
  endfunction

  task automatic push_item(input kind_t k, input int unsigned c, input int unsigned r,
                           input logic signed [ValW-1:0] g, input int unsigned i,
                           input logic signed [ValW-1:0] a, input logic signed [ValW-1:0] b,
                           input logic signed [ValW-1:0] d);
    scatter_item_t it;
    scatter_item_t ld;
    it = '{k, c[CoordW-1:0], r[CoordW-1:0], g, i[IdxW-1:0], a, b, d};
    // an in-bounds point never reads a pixel that was not loaded
    if (k == KIND_ACCUM && image_status(it.col, it.row) == STAT_OK &&
        !pixel_loaded[pixel_addr(it.col, it.row)]) begin
      ld = '{KIND_LOAD, it.col, it.row, a, '0, a, a, a};
      pixel_loaded[pixel_addr(it.col, it.row)] = 1'b1;
      pending_items = {pending_items, ld};
    end
    if (k == KIND_LOAD && image_status(it.col, it.row) == STAT_OK)
      pixel_loaded[pixel_addr(it.col, it.row)] = 1'b1;
    pending_items = {pending_items, it};
  endtask

  task automatic push_simple(input kind_t k, input int unsigned c, input int unsigned r,
                             input logic signed [ValW-1:0] g, input int unsigned i,
                             input logic signed [ValW-1:0] d);
    push_item(k, c, r, g, i, d, d, d);
  endtask

  function automatic int unsigned valid_entry_limit();
    longint n;
    n = longint'(map_w) * map_h;
    return (n > EntryCount) ? EntryCount : int'(n);
  endfunction

  // point with its pixel in bounds and loaded beforehand; the index may be out of range
  task automatic push_point();
    int unsigned c, r, i, lim;
    c = $urandom_range(img_w - 1);
    r = $urandom_range(img_h - 1);
    if (!pixel_loaded[pixel_addr(c, r)])
      push_simple(KIND_LOAD, c, r, rand_val(), $urandom, rand_val());
    lim = valid_entry_limit();
    case ($urandom_range(9))
      0: i = $urandom_range(24'hFFFFFF);
      1: i = lim;
      2, 3, 4: i = $urandom_range((lim < 8 ? lim : 8) - 1);
      default: i = $urandom_range(lim - 1);
    endcase
    push_item(KIND_ACCUM, c, r, $urandom, i, rand_val(), rand_val(), rand_val());
  endtask

  task automatic push_random(input int unsigned n);
    int unsigned lim;
    for (int k = 0; k < n; k++) begin
      lim = valid_entry_limit();
      case ($urandom_range(99)) inside
        [0:39]: push_point();
        [40:54]: push_simple(KIND_LOAD, $urandom_range(img_w - 1), $urandom_range(img_h - 1),
                             rand_val(), $urandom, rand_val());
        [55:62]: push_item(($urandom_range(1) ? KIND_LOAD : KIND_ACCUM), $urandom, $urandom,
                           rand_val(), $urandom, rand_val(), rand_val(), rand_val());
        [63:64]: push_simple(KIND_CLEAR, $urandom, $urandom, $urandom, $urandom, rand_val());
        [65:89]: push_simple(KIND_READ, $urandom, $urandom, $urandom,
                             $urandom_range(($urandom_range(1) ? (lim < 8 ? lim : 8) : lim) - 1),
                             rand_val());
        default: push_simple(KIND_READ, $urandom, $urandom, $urandom,
                             $urandom_range(24'hFFFFFF), rand_val());
      endcase
    end
  endtask

  // checked at the falling edge so that the driver's updates have settled
  task automatic wait_idle();
    do @(negedge clk);
    while (pending_items.size() > 0 || in_valid || expected_entries.size() > 0);
    repeat (10) @(posedge clk);
  endtask

  task automatic write_regs(input int unsigned iw, input int unsigned ih,
                            input int unsigned mw, input int unsigned mh);
    wait_idle();
    cfg_we <= 1'b1;
    cfg_index <= REG_IMAGE_WIDTH;
    cfg_data <= iw[CfgDataW-1:0];
    @(posedge clk);
    cfg_index <= REG_IMAGE_HEIGHT;
    cfg_data <= ih[CfgDataW-1:0];
    @(posedge clk);
    cfg_index <= REG_MAP_WIDTH;
    cfg_data <= mw[CfgDataW-1:0];
    @(posedge clk);
    cfg_index <= REG_MAP_HEIGHT;
    cfg_data <= mh[CfgDataW-1:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    img_w = iw;
    img_h = ih;
    map_w = mw;
    map_h = mh;
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // accumulators are undefined until the first clear
    push_simple(KIND_CLEAR, 0, 0, 0, 0, 0);
    push_simple(KIND_READ, 0, 0, 0, 0, 0);
    push_simple(KIND_READ, 0, 0, 0, 4095, 0);
    push_simple(KIND_READ, 0, 0, 0, 4096, 0);
    push_simple(KIND_READ, 0, 0, 0, 24'hFFFFFF, 0);
    push_simple(KIND_LOAD, 0, 0, ValMax, 0, 0);
    push_simple(KIND_LOAD, 255, 255, ValMin, 0, 0);
    push_simple(KIND_LOAD, 256, 0, 1, 0, 0);
    push_simple(KIND_LOAD, 16'hFFFF, 16'hFFFF, 1, 0, 0);
    push_simple(KIND_LOAD, 0, 256, 1, 0, 0);
    push_simple(KIND_LOAD, 1, 0, 1, 0, 0);
    // drive one entry into positive saturation, another into negative
    repeat (3) push_simple(KIND_ACCUM, 0, 0, 0, 5, ValMax);
    push_simple(KIND_ACCUM, 255, 255, 0, 6, ValMin);
    repeat (3) push_simple(KIND_ACCUM, 255, 255, 0, 7, ValMax);
    push_simple(KIND_ACCUM, 16'hFFFF, 0, 0, 5, ValMax);
    push_simple(KIND_ACCUM, 0, 16'hFFFF, 0, 5, ValMax);
    push_simple(KIND_ACCUM, 0, 0, 0, 4096, ValMax);
    // half-lsb ties round up: +0.5 lsb gives 1, -0.5 lsb gives 0
    push_item(KIND_ACCUM, 1, 0, 0, 8, 32'sh8000, -32'sh8000, 32'sh7FFF);
    for (int i = 5; i <= 8; i++) push_simple(KIND_READ, 0, 0, 0, i, 0);
    push_random(230);

    write_regs(1, 1, 4096, 1);
    push_random(245);
    write_regs(256, 256, 1, 4096);
    push_random(245);
    write_regs(17, 9, 4096, 4096);
    push_random(245);
    write_regs(100, 200, 37, 50);
    push_random(245);
    write_regs(256, 256, 64, 64);
    push_random(245);

    wait_idle();
    repeat (50) @(posedge clk);
    if (mismatches == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end

  initial begin
    #20ms;
    $display("Some tests failed");
    $finish;
  end

endmodule
